@@ sv/hlw1_pkg.sv @@
package hlw1_pkg;

  // Event kinds carried on the input channel's tuser
  typedef enum logic [2:0] {
    EV_FRAME   = 3'd0,
    EV_TICK    = 3'd1,
    EV_TX      = 3'd2,
    EV_ENABLE  = 3'd3,
    EV_DISABLE = 3'd4
  } kind_t;

  // Received frame types; codes above FT_OTHER count as other
  typedef enum logic [2:0] {
    FT_I     = 3'd0,
    FT_RR    = 3'd1,
    FT_UA    = 3'd2,
    FT_DM    = 3'd3,
    FT_OTHER = 3'd4
  } frame_type_t;

  typedef enum logic [1:0] {
    SEND_I    = 2'd0,
    SEND_RR   = 2'd1,
    SEND_SABM = 2'd2
  } send_type_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BUSY    = 2'd1,
    STAT_DOWN    = 2'd2,
    STAT_IGNORED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_RESET    = 2'd1,
    MODE_AWAIT_UA = 2'd2,
    MODE_UP       = 2'd3
  } link_mode_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_CHANNEL     = 3'd0;
  localparam logic [2:0] CFG_KEEPALIVE   = 3'd1;
  localparam logic [2:0] CFG_RETRANSMIT  = 3'd2;
  localparam logic [2:0] CFG_MAX_RETX    = 3'd3;
  localparam logic [2:0] CFG_MAX_KA      = 3'd4;

  localparam logic [15:0] KEEPALIVE_RESET  = 16'd1000;
  localparam logic [15:0] RETRANSMIT_RESET = 16'd200;
  localparam logic [7:0]  MAX_RETX_RESET   = 8'd3;
  localparam logic [7:0]  MAX_KA_RESET     = 8'd3;

  localparam logic [2:0]  SEQ_RESET = 3'd7;

  typedef struct packed {
    logic [3:0]  channel_number;
    logic [15:0] keepalive_ticks;
    logic [15:0] retransmit_ticks;
    logic [7:0]  max_retransmits;
    logic [7:0]  keepalive_limit;
  } cfg_t;

  typedef struct packed {
    logic       has_payload;
    logic       cr_bit;
    logic [3:0] frame_channel;
    logic [2:0] frame_nr;
    logic [2:0] frame_ns;
    logic       frame_short;
    logic [2:0] frame_type;
    logic [2:0] kind;
  } evt_t;

  typedef struct packed {
    logic [1:0] link_state;
    logic       can_send;
    logic [1:0] status;
    logic       deliver_cr;
    logic       deliver;
    logic       send_payload;
    logic       send_cr;
    logic [2:0] send_nr;
    logic [2:0] send_ns;
    logic [1:0] send_type;
    logic       send_valid;
  } res_t;

endpackage

@@ sv/hdlc_link_window1_controller.sv @@
// Link controller for an HDLC-style balanced link with a send window of one
// I-frame and modulo-8 sequence numbers. Each request on the input stream is
// one event (received frame, timer tick, transmit request, enable, disable)
// and yields exactly one result: the descriptor of a frame to send (SABM, RR
// or I-frame), a delivery flag for received user data, a status code, the
// can-send flag and the link state. The block takes one event per clock
// while the result side is not stalled; an accepted event waits in the input
// register, then one pass of next-state logic writes its result into the
// result register once that register is free, and it is offered from there.
// The input register takes one more event while a result waits to be
// taken; in_tready then drops until the result side moves, so a stall on
// the result side holds at most one more event.
// Configuration registers are written through the cfg_ port and must only
// change while no event is in flight; cfg_ready is always high.
module hdlc_link_window1_controller #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: frame_type[2:0], frame_short[3], frame_ns[6:4], frame_nr[9:7],
  //        frame_channel[13:10], cr_bit[14], has_payload[15]
  input  logic [15:0] in_tdata,
  // tuser: kind[2:0]
  input  logic [2:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: send_valid[0], send_type[2:1], send_ns[5:3], send_nr[8:6],
  //        send_cr[9], send_payload[10], deliver[11], deliver_cr[12],
  //        status[14:13], can_send[15], link_state[17:16], zero[23:18]
  output logic [23:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import hlw1_pkg::*;

  cfg_t  cfg;
  evt_t  evt_r;
  logic  in_valid_r;
  res_t  res;
  res_t  out_r;
  logic  out_valid_r;
  logic  advance;

  assign cfg_ready = 1'b1;

  hlw1_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Move the held event into the result register when that slot is free
  // or is being emptied this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      evt_r <= {in_tdata, in_tuser};
    end
  end

  // Link state and the next-state pass; state updates when the event advances
  hlw1_link_fsm #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .evt   (evt_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r};

`ifndef SYNTHESIS
  // An advancing event always lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced event did not reach the result register");

  // Send descriptor fields stay zero when nothing is sent
  a_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.send_valid) |->
      (out_r.send_type == 2'd0 && out_r.send_ns == 3'd0 && out_r.send_nr == 3'd0 &&
       out_r.send_cr == 1'b0 && out_r.send_payload == 1'b0))
    else $error("send fields set without send_valid");

  // can_send only while the link is up
  a_can_send_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.can_send) |-> (out_r.link_state == MODE_UP))
    else $error("can_send outside link up");

  // deliver_cr stays low unless data is delivered
  a_deliver_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.deliver) |-> !out_r.deliver_cr)
    else $error("deliver_cr without deliver");
`endif

endmodule

@@ sv/hlw1_cfg_regs.sv @@
module hlw1_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [15:0]        wr_data,
  output hlw1_pkg::cfg_t     cfg
);
  import hlw1_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_number   <= 4'd0;
      cfg_r.keepalive_ticks  <= KEEPALIVE_RESET;
      cfg_r.retransmit_ticks <= RETRANSMIT_RESET;
      cfg_r.max_retransmits  <= MAX_RETX_RESET;
      cfg_r.keepalive_limit  <= MAX_KA_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_CHANNEL:    cfg_r.channel_number   <= wr_data[3:0];
        CFG_KEEPALIVE:  cfg_r.keepalive_ticks  <= wr_data;
        CFG_RETRANSMIT: cfg_r.retransmit_ticks <= wr_data;
        CFG_MAX_RETX:   cfg_r.max_retransmits  <= wr_data[7:0];
        CFG_MAX_KA:     cfg_r.keepalive_limit  <= wr_data[7:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/hlw1_link_fsm.sv @@
module hlw1_link_fsm #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  hlw1_pkg::evt_t  evt,
  input  hlw1_pkg::cfg_t  cfg,
  output hlw1_pkg::res_t  res
);
  import hlw1_pkg::*;

  localparam int EW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [EW-1:0] TMAX = EW'({TIMER_WIDTH{1'b1}});

  link_mode_t              mode_r, mode_nxt;
  logic [2:0]              lss_r, lss_nxt;     // local send sequence
  logic [2:0]              prs_r, prs_nxt;     // peer receive sequence
  logic [2:0]              pss_r, pss_nxt;     // peer send sequence
  logic [7:0]              rtx_r, rtx_nxt;
  logic [7:0]              ka_r, ka_nxt;
  logic [TIMER_WIDTH-1:0]  timer_r, timer_nxt;
  logic                    held_valid_r, held_valid_nxt;
  logic                    held_cr_r, held_cr_nxt;
  logic                    held_data_r, held_data_nxt;

  logic [EW-1:0]           ka_ext, rt_ext;
  logic [TIMER_WIDTH-1:0]  ka_load, rt_load;

  // Saturate timer loads to the timer width
  assign ka_ext  = EW'(cfg.keepalive_ticks);
  assign rt_ext  = EW'(cfg.retransmit_ticks);
  assign ka_load = (ka_ext > TMAX) ? TMAX[TIMER_WIDTH-1:0] : ka_ext[TIMER_WIDTH-1:0];
  assign rt_load = (rt_ext > TMAX) ? TMAX[TIMER_WIDTH-1:0] : rt_ext[TIMER_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_DISABLED;
      lss_r        <= SEQ_RESET;
      prs_r        <= 3'd0;
      pss_r        <= 3'd0;
      rtx_r        <= 8'd0;
      ka_r         <= 8'd0;
      timer_r      <= '0;
      held_valid_r <= 1'b0;
      held_cr_r    <= 1'b0;
      held_data_r  <= 1'b0;
    end else if (fire) begin
      mode_r       <= mode_nxt;
      lss_r        <= lss_nxt;
      prs_r        <= prs_nxt;
      pss_r        <= pss_nxt;
      rtx_r        <= rtx_nxt;
      ka_r         <= ka_nxt;
      timer_r      <= timer_nxt;
      held_valid_r <= held_valid_nxt;
      held_cr_r    <= held_cr_nxt;
      held_data_r  <= held_data_nxt;
    end
  end

  always_comb begin
    logic retry;
    logic resend;
    logic sabm;
    logic [8:0] rtx_inc;
    logic [8:0] ka_inc;

    mode_nxt       = mode_r;
    lss_nxt        = lss_r;
    prs_nxt        = prs_r;
    pss_nxt        = pss_r;
    rtx_nxt        = rtx_r;
    ka_nxt         = ka_r;
    timer_nxt      = timer_r;
    held_valid_nxt = held_valid_r;
    held_cr_nxt    = held_cr_r;
    held_data_nxt  = held_data_r;
    res            = '0;
    res.status     = STAT_OK;
    retry          = 1'b0;
    resend         = 1'b0;
    sabm           = 1'b0;
    rtx_inc        = {1'b0, rtx_r} + 9'd1;
    ka_inc         = {1'b0, ka_r} + 9'd1;

    case (evt.kind)
      EV_FRAME: begin
        if (mode_r == MODE_DISABLED || evt.frame_short) begin
          res.status = STAT_IGNORED;
        end else begin
          if (mode_r == MODE_RESET) begin
            if (evt.frame_type == FT_DM) sabm = 1'b1;
            else res.status = STAT_IGNORED;
          end else if (mode_r == MODE_AWAIT_UA) begin
            if (evt.frame_type == FT_UA) begin
              mode_nxt  = MODE_UP;
              timer_nxt = ka_load;
            end else if (evt.frame_type == FT_DM) begin
              sabm = 1'b1;
            end else begin
              res.status = STAT_IGNORED;
            end
          end else begin
            if (evt.frame_type == FT_I) begin
              timer_nxt      = ka_load;
              prs_nxt        = evt.frame_nr;
              pss_nxt        = evt.frame_ns;
              res.send_valid = 1'b1;
              res.send_type  = SEND_RR;
              res.send_nr    = 3'(evt.frame_ns + 3'd1);
            end else if (evt.frame_type == FT_RR) begin
              prs_nxt = evt.frame_nr;
              if (3'(lss_r + 3'd1) != evt.frame_nr) begin
                retry = 1'b1;
              end else begin
                rtx_nxt   = 8'd0;
                ka_nxt    = 8'd0;
                timer_nxt = ka_load;
              end
            end else if (evt.frame_type == FT_DM) begin
              sabm = 1'b1;
            end else begin
              res.status = STAT_IGNORED;
            end
          end
          if (evt.frame_type == FT_I && evt.frame_channel == cfg.channel_number &&
              evt.has_payload) begin
            res.deliver    = 1'b1;
            res.deliver_cr = evt.cr_bit;
          end
        end
      end
      EV_TICK: begin
        if (timer_r != '0) begin
          timer_nxt = timer_r - TIMER_WIDTH'(1);
          if (timer_r == TIMER_WIDTH'(1) && mode_r == MODE_UP) begin
            if (3'(lss_r + 3'd1) != prs_r) begin
              retry = 1'b1;
            end else if (ka_inc > {1'b0, cfg.keepalive_limit}) begin
              mode_nxt = MODE_RESET;
              lss_nxt  = SEQ_RESET;
              prs_nxt  = 3'd0;
              pss_nxt  = 3'd0;
              rtx_nxt  = 8'd0;
              ka_nxt   = 8'd0;
            end else begin
              // empty keepalive I-frame
              ka_nxt         = ka_inc[7:0];
              held_valid_nxt = 1'b1;
              held_cr_nxt    = 1'b1;
              held_data_nxt  = 1'b0;
              lss_nxt        = 3'(lss_r + 3'd1);
              resend         = 1'b1;
            end
          end
        end
      end
      EV_TX: begin
        if (evt.has_payload) begin
          if (mode_r != MODE_UP) begin
            res.status = STAT_DOWN;
          end else if (3'(lss_r + 3'd1) != prs_r) begin
            res.status = STAT_BUSY;
          end else begin
            held_valid_nxt = 1'b1;
            held_cr_nxt    = evt.cr_bit;
            held_data_nxt  = 1'b1;
            lss_nxt        = 3'(lss_r + 3'd1);
            resend         = 1'b1;
          end
        end
      end
      EV_ENABLE: sabm = 1'b1;
      EV_DISABLE: begin
        mode_nxt  = MODE_DISABLED;
        timer_nxt = '0;
      end
      default: ;
    endcase

    if (sabm) begin
      lss_nxt        = SEQ_RESET;
      prs_nxt        = 3'd0;
      pss_nxt        = 3'd0;
      rtx_nxt        = 8'd0;
      ka_nxt         = 8'd0;
      mode_nxt       = MODE_AWAIT_UA;
      res.send_valid = 1'b1;
      res.send_type  = SEND_SABM;
      res.send_cr    = 1'b1;
    end

    // Retry: resend the held frame or drop the link when out of retries
    if (retry) begin
      if (rtx_inc > {1'b0, cfg.max_retransmits}) begin
        mode_nxt = MODE_RESET;
        lss_nxt  = SEQ_RESET;
        prs_nxt  = 3'd0;
        pss_nxt  = 3'd0;
        rtx_nxt  = 8'd0;
        ka_nxt   = 8'd0;
      end else begin
        rtx_nxt = rtx_inc[7:0];
        resend  = 1'b1;
      end
    end

    if (resend && held_valid_nxt) begin
      timer_nxt        = rt_load;
      res.send_valid   = 1'b1;
      res.send_type    = SEND_I;
      res.send_ns      = lss_nxt;
      res.send_nr      = 3'(pss_nxt + 3'd1);
      res.send_cr      = held_cr_nxt;
      res.send_payload = held_data_nxt;
    end

    res.can_send   = (mode_nxt == MODE_UP) && (3'(lss_nxt + 3'd1) == prs_nxt);
    res.link_state = mode_nxt;
  end

endmodule

@@ verif/hdlc_link_window1_controller_tb.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the window-of-one HDLC link controller.
// Every event request sent on the in_ stream is run through a behavioral
// model of the link state machine kept in this module; the predicted
// response descriptor is queued and compared field by field with each
// response taken from the out_ stream. A short directed sequence walks the
// link through setup, data transfer, keepalive, retry exhaustion and
// shutdown, then random traffic runs under several register settings with
// random gaps on the request side and random stalls on the response side.
module hdlc_link_window1_controller_tb;
  import hlw1_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // Codes outside the defined sets; the block must treat them as harmless.
  localparam logic [2:0] KIND_UNUSED = 3'd5;
  localparam logic [2:0] CFG_UNUSED  = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic [15:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  hdlc_link_window1_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Link model state and register shadows
  // ---------------------------------------------------------------------
  link_mode_t  mode;
  logic [2:0]  tx_seq;       // N(S) of our last I-frame
  logic [2:0]  ack_seq;      // last N(R) heard from the peer
  logic [2:0]  rx_seq;       // last N(S) heard from the peer
  logic [7:0]  retry_cnt;
  logic [7:0]  ka_cnt;
  logic [15:0] timer_cnt;    // zero means disarmed
  logic        held_valid;
  logic        held_cr;
  logic        held_data;

  logic [3:0]  chan_reg;
  logic [15:0] ka_load;
  logic [15:0] rt_load;
  logic [7:0]  retry_limit;
  logic [7:0]  ka_limit;

  res_t        resp;         // response under construction
  res_t        pending_responses[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  logic        steady_flow = 1'b0;  // suppress gaps and stalls on both sides

  function automatic logic [2:0] seq_after(logic [2:0] s);
    return s + 3'd1;
  endfunction

  function automatic logic window_clear();
    return mode == MODE_UP && seq_after(tx_seq) == ack_seq;
  endfunction

  function automatic void put_frame(send_type_t t, logic [2:0] ns, logic [2:0] nr,
                                    logic cr, logic pl);
    resp.send_valid   = 1'b1;
    resp.send_type    = t;
    resp.send_ns      = ns;
    resp.send_nr      = nr;
    resp.send_cr      = cr;
    resp.send_payload = pl;
  endfunction

  // SABM out, sequence numbers and counts back to their start values
  function automatic void restart_link();
    tx_seq    = SEQ_RESET;
    ack_seq   = 3'd0;
    rx_seq    = 3'd0;
    put_frame(SEND_SABM, 3'd0, 3'd0, 1'b1, 1'b0);
    mode      = MODE_AWAIT_UA;
    retry_cnt = 8'd0;
    ka_cnt    = 8'd0;
  endfunction

  // Fall back to reset; leave the timer and the held frame alone
  function automatic void drop_to_reset();
    mode      = MODE_RESET;
    tx_seq    = SEQ_RESET;
    ack_seq   = 3'd0;
    rx_seq    = 3'd0;
    retry_cnt = 8'd0;
    ka_cnt    = 8'd0;
  endfunction

  function automatic void resend_held();
    if (!held_valid) return;
    timer_cnt = rt_load;
    put_frame(SEND_I, tx_seq, seq_after(rx_seq), held_cr, held_data);
  endfunction

  function automatic void retry_or_drop();
    if (retry_cnt >= retry_limit) begin
      drop_to_reset();
    end else begin
      retry_cnt = retry_cnt + 8'd1;
      resend_held();
    end
  endfunction

  function automatic void timer_expired();
    if (mode != MODE_UP) return;
    if (seq_after(tx_seq) != ack_seq) begin
      retry_or_drop();
    end else if (ka_cnt >= ka_limit) begin
      drop_to_reset();
    end else begin
      // empty keepalive I-frame takes the window
      ka_cnt     = ka_cnt + 8'd1;
      held_valid = 1'b1;
      held_cr    = 1'b1;
      held_data  = 1'b0;
      tx_seq     = seq_after(tx_seq);
      resend_held();
    end
  endfunction

  // Advance the link model by one event and return the response it gives.
  function automatic res_t predict_link_response(evt_t ev);
    logic ignored;
    resp    = '0;
    ignored = 1'b0;
    case (ev.kind)
      EV_FRAME: begin
        if (mode == MODE_DISABLED || ev.frame_short) begin
          resp.status = STAT_IGNORED;
        end else begin
          case (mode)
            MODE_RESET: begin
              if (ev.frame_type == FT_DM) restart_link();
              else ignored = 1'b1;
            end
            MODE_AWAIT_UA: begin
              if (ev.frame_type == FT_UA) begin
                mode      = MODE_UP;
                timer_cnt = ka_load;
              end else if (ev.frame_type == FT_DM) begin
                restart_link();
              end else begin
                ignored = 1'b1;
              end
            end
            default: begin
              if (ev.frame_type == FT_I) begin
                timer_cnt = ka_load;
                ack_seq   = ev.frame_nr;
                rx_seq    = ev.frame_ns;
                put_frame(SEND_RR, 3'd0, seq_after(ev.frame_ns), 1'b0, 1'b0);
              end else if (ev.frame_type == FT_RR) begin
                ack_seq = ev.frame_nr;
                if (seq_after(tx_seq) != ev.frame_nr) begin
                  retry_or_drop();
                end else begin
                  retry_cnt = 8'd0;
                  ka_cnt    = 8'd0;
                  timer_cnt = ka_load;
                end
              end else if (ev.frame_type == FT_DM) begin
                restart_link();
              end else begin
                ignored = 1'b1;
              end
            end
          endcase
          if (ignored) resp.status = STAT_IGNORED;
          // user data is delivered even when the frame is ignored for control
          if (ev.frame_type == FT_I && ev.frame_channel == chan_reg && ev.has_payload) begin
            resp.deliver    = 1'b1;
            resp.deliver_cr = ev.cr_bit;
          end
        end
      end
      EV_TICK: begin
        if (timer_cnt != 16'd0) begin
          timer_cnt = timer_cnt - 16'd1;
          if (timer_cnt == 16'd0) timer_expired();
        end
      end
      EV_TX: begin
        if (ev.has_payload) begin
          if (mode != MODE_UP) begin
            resp.status = STAT_DOWN;
          end else if (!window_clear()) begin
            resp.status = STAT_BUSY;
          end else begin
            held_valid = 1'b1;
            held_cr    = ev.cr_bit;
            held_data  = 1'b1;
            tx_seq     = seq_after(tx_seq);
            resend_held();
          end
        end
      end
      EV_ENABLE: restart_link();
      EV_DISABLE: begin
        mode      = MODE_DISABLED;
        timer_cnt = 16'd0;
      end
      default: ;
    endcase
    resp.can_send   = window_clear();
    resp.link_state = mode;
    return resp;
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------
  function automatic evt_t link_event(logic [2:0] kind, logic [2:0] ftype, logic is_short,
                                      logic [2:0] ns, logic [2:0] nr, logic [3:0] ch,
                                      logic cr, logic pay);
    evt_t ev;
    ev.kind          = kind;
    ev.frame_type    = ftype;
    ev.frame_short   = is_short;
    ev.frame_ns      = ns;
    ev.frame_nr      = nr;
    ev.frame_channel = ch;
    ev.cr_bit        = cr;
    ev.has_payload   = pay;
    return ev;
  endfunction

  // Hold the request until it is taken; queue its predicted response at the
  // accepting edge. Enter and leave on a falling edge.
  task automatic send_event(evt_t ev);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 17);
    repeat (gap) @(negedge clk);
    in_tdata  = ev[18:3];
    in_tuser  = ev.kind;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_responses.push_back(predict_link_response(ev));
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_register(logic [2:0] idx, logic [15:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CHANNEL:    chan_reg    = value[3:0];
      CFG_KEEPALIVE:  ka_load     = value;
      CFG_RETRANSMIT: rt_load     = value;
      CFG_MAX_RETX:   retry_limit = value[7:0];
      CFG_MAX_KA:     ka_limit    = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drain every outstanding response, then let the pipeline settle.
  task automatic wait_idle();
    while (pending_responses.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic apply_settings(logic [3:0] chan, logic [15:0] ka, logic [15:0] rt,
                                logic [7:0] max_retx, logic [7:0] max_ka);
    logic [15:0] noise;
    wait_idle();
    noise = 16'($urandom);
    // unused upper bits carry noise; only the register width counts
    write_register(CFG_CHANNEL, {noise[15:4], chan});
    write_register(CFG_KEEPALIVE, ka);
    write_register(CFG_RETRANSMIT, rt);
    write_register(CFG_MAX_RETX, {noise[7:0], max_retx});
    write_register(CFG_MAX_KA, {noise[15:8], max_ka});
  endtask

  // Mostly well-formed traffic steered by the link state, with some noise.
  function automatic evt_t random_link_event();
    logic [31:0] raw;
    int          pick;
    evt_t        ev;
    raw  = $urandom;
    ev   = raw[18:0];
    pick = $urandom_range(0, 99);
    if (pick < 8) return ev;
    ev.frame_short = ($urandom_range(0, 19) == 0);
    ev.kind        = EV_FRAME;
    case (mode)
      MODE_DISABLED: begin
        if (pick < 70) ev.kind = EV_ENABLE;
        else ev.kind = 3'($urandom_range(0, 4));
      end
      MODE_RESET: begin
        if (pick < 50) ev.frame_type = FT_DM;
        else if (pick < 65) ev.kind = EV_ENABLE;
        else ev.kind = 3'($urandom_range(0, 4));
      end
      MODE_AWAIT_UA: begin
        if (pick < 60) ev.frame_type = FT_UA;
        else if (pick < 70) ev.frame_type = FT_DM;
        else if (pick < 80) ev.frame_type = FT_I;
        else ev.kind = 3'($urandom_range(0, 4));
      end
      default: begin
        if (pick < 40) begin
          ev.kind = EV_TICK;
        end else if (pick < 58) begin
          ev.kind        = EV_TX;
          ev.has_payload = ($urandom_range(0, 7) != 0);
        end else if (pick < 95) begin
          // peer frame acknowledging our last I-frame most of the time
          ev.frame_type = (pick < 76) ? FT_I : FT_RR;
          if ($urandom_range(0, 6) != 0) ev.frame_nr = seq_after(tx_seq);
          if ($urandom_range(0, 3) != 0) ev.frame_channel = chan_reg;
        end else if (pick < 97) begin
          ev.frame_type = FT_DM;
        end else begin
          ev.kind = 3'($urandom_range(0, 4));
        end
      end
    endcase
    return ev;
  endfunction

  // ---------------------------------------------------------------------
  // Response side: stall at random, compare each response taken
  // ---------------------------------------------------------------------
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!(out_tvalid && rst_n));
      @(negedge clk);
    end
  end

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[17:0];
      if (pending_responses.size() == 0) begin
        $display("%0t ns: unexpected response, expected none, actual %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("send_valid", want.send_valid, got.send_valid);
        check_field("send_type", want.send_type, got.send_type);
        check_field("send_ns", want.send_ns, got.send_ns);
        check_field("send_nr", want.send_nr, got.send_nr);
        check_field("send_cr", want.send_cr, got.send_cr);
        check_field("send_payload", want.send_payload, got.send_payload);
        check_field("deliver", want.deliver, got.deliver);
        check_field("deliver_cr", want.deliver_cr, got.deliver_cr);
        check_field("status", want.status, got.status);
        check_field("can_send", want.can_send, got.can_send);
        check_field("link_state", want.link_state, got.link_state);
        check_field("pad bits", 0, out_tdata[23:18]);
      end
    end
  end

  // Watchdog: bail out if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Disabled link: frames ignored, transmit refused, stray events harmless.
  task automatic test_disabled_link();
    send_event(link_event(EV_FRAME, FT_I, 1'b0, 3'd1, 3'd2, 4'd0, 1'b1, 1'b1));
    send_event(link_event(EV_TX, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b1, 1'b1));
    send_event(link_event(EV_TX, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b1, 1'b0));
    send_event(link_event(EV_TICK, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b0, 1'b0));
    send_event(link_event(KIND_UNUSED, FT_OTHER, 1'b1, 3'd7, 3'd7, 4'd15, 1'b1, 1'b1));
  endtask

  // SABM/UA exchange, short frame, data while awaiting UA, DM restart,
  // a frame for another channel, and a resend with nothing held.
  task automatic test_link_setup();
    apply_settings(4'd5, 16'd2, 16'd1, 8'd1, 8'd1);
    send_event(link_event(EV_ENABLE, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b0, 1'b0));
    send_event(link_event(EV_FRAME, FT_UA, 1'b1, 3'd0, 3'd0, 4'd5, 1'b0, 1'b0));
    send_event(link_event(EV_FRAME, FT_I, 1'b0, 3'd2, 3'd0, 4'd5, 1'b1, 1'b1));
    send_event(link_event(EV_FRAME, FT_DM, 1'b0, 3'd0, 3'd0, 4'd5, 1'b0, 1'b0));
    send_event(link_event(EV_FRAME, FT_UA, 1'b0, 3'd0, 3'd0, 4'd5, 1'b0, 1'b0));
    send_event(link_event(EV_FRAME, FT_I, 1'b0, 3'd0, 3'd3, 4'd6, 1'b0, 1'b1));
    send_event(link_event(EV_TICK, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b0, 1'b0));
    send_event(link_event(EV_TICK, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b0, 1'b0));
    send_event(link_event(EV_FRAME, FT_RR, 1'b0, 3'd0, 3'd0, 4'd5, 1'b0, 1'b0));
  endtask

  // One I-frame out, busy window, retransmit, drop on exhausted retries,
  // then bring the link back up from reset.
  task automatic test_send_window();
    send_event(link_event(EV_TX, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b0, 1'b1));
    send_event(link_event(EV_TX, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b1, 1'b1));
    send_event(link_event(EV_TICK, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b0, 1'b0));
    send_event(link_event(EV_TICK, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b0, 1'b0));
    send_event(link_event(EV_FRAME, FT_DM, 1'b0, 3'd0, 3'd0, 4'd5, 1'b0, 1'b0));
    send_event(link_event(EV_FRAME, FT_UA, 1'b0, 3'd0, 3'd0, 4'd5, 1'b0, 1'b0));
  endtask

  // Data in with RR out, keepalive, acknowledgement, wrong N(R) until the
  // link drops with the timer still running, then shutdown.
  task automatic test_keepalive_and_ack();
    send_event(link_event(EV_FRAME, FT_I, 1'b0, 3'd3, 3'd0, 4'd5, 1'b0, 1'b1));
    send_event(link_event(EV_TICK, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b0, 1'b0));
    send_event(link_event(EV_TICK, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b0, 1'b0));
    send_event(link_event(EV_FRAME, FT_RR, 1'b0, 3'd0, 3'd1, 4'd5, 1'b1, 1'b0));
    send_event(link_event(EV_TX, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b1, 1'b1));
    send_event(link_event(EV_FRAME, FT_RR, 1'b0, 3'd0, 3'd1, 4'd5, 1'b0, 1'b0));
    send_event(link_event(EV_FRAME, FT_RR, 1'b0, 3'd0, 3'd1, 4'd5, 1'b0, 1'b0));
    send_event(link_event(EV_TICK, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b0, 1'b0));
    send_event(link_event(EV_DISABLE, FT_I, 1'b0, 3'd0, 3'd0, 4'd0, 1'b0, 1'b0));
  endtask

  task automatic run_traffic_phase(logic [3:0] chan, logic [15:0] ka, logic [15:0] rt,
                                   logic [7:0] max_retx, logic [7:0] max_ka,
                                   logic no_idle, int count);
    apply_settings(chan, ka, rt, max_retx, max_ka);
    steady_flow = no_idle;
    repeat (count) send_event(random_link_event());
    steady_flow = 1'b0;
  endtask

  // Random traffic across register settings, extremes first.
  task automatic test_random_traffic();
    int n;
    // a write to an unmapped index must change nothing
    wait_idle();
    write_register(CFG_UNUSED, 16'($urandom));
    run_traffic_phase(4'd15, 16'd3, 16'd2, 8'd0, 8'd0, 1'b0, 125);
    // back-to-back requests with no stalls, largest retry counts
    run_traffic_phase(4'd0, 16'd1, 16'd1, 8'd255, 8'd255, 1'b1, 125);
    // zero loads disarm the timer
    run_traffic_phase(4'($urandom_range(0, 15)), 16'd0, 16'd2, 8'd2, 8'd2, 1'b0, 125);
    run_traffic_phase(4'($urandom_range(0, 15)), 16'd4, 16'd0, 8'd1, 8'd1, 1'b0, 125);
    run_traffic_phase(4'($urandom_range(0, 15)), 16'hffff, 16'hffff, 8'd3, 8'd3, 1'b0, 60);
    for (n = 0; n < 3; n++) begin
      run_traffic_phase(4'($urandom_range(0, 15)),
                        16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                        8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)), 1'b0, 150);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    // drive every input to a known value before reset
    rst_n     = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    in_tvalid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    // model state and register shadows at their reset values
    mode        = MODE_DISABLED;
    tx_seq      = SEQ_RESET;
    ack_seq     = 3'd0;
    rx_seq      = 3'd0;
    retry_cnt   = 8'd0;
    ka_cnt      = 8'd0;
    timer_cnt   = 16'd0;
    held_valid  = 1'b0;
    held_cr     = 1'b0;
    held_data   = 1'b0;
    chan_reg    = 4'd0;
    ka_load     = KEEPALIVE_RESET;
    rt_load     = RETRANSMIT_RESET;
    retry_limit = MAX_RETX_RESET;
    ka_limit    = MAX_KA_RESET;

    // hold reset, then release it on a falling edge
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_disabled_link();
    test_link_setup();
    test_send_window();
    test_keepalive_and_ack();
    test_random_traffic();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
